// File: src/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in this cycle implies consequent in the same cycle.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

// File: src/wnlt_pkg.sv
// Shared constants, entry type and control/status bundles of the neighbor list.
// No dependencies; imported by every module of the block.
package wnlt_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 10;
    localparam int VTX_W    = 10;
    localparam int WT_W     = 32;

    // Operation codes
    localparam logic [1:0] KIND_ADD    = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_FIND   = 2'd2;
    localparam logic [1:0] KIND_LIST   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_EMPTY    = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [WT_W-1:0]  wt;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic       op_load;         // latch key and weight of the accepted word
        logic       ptr_clr;
        logic       ptr_inc;
        logic       ptr_after_match; // walk pointer to the entry after the match
        logic       rd_en;           // read the store at the walk pointer
        logic       shift_wr;        // write the read entry one place lower
        logic       add_wr;          // append key and weight at the tail
        logic       cnt_inc;
        logic       cnt_dec;
        logic       out_load;
        logic [1:0] out_status;
        logic       out_tag;         // report the vertex id as source
        logic       out_entry;       // report the read entry
        logic       out_last;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic ptr_lt_cnt;
        logic rd_vld;
        logic rd_match;
        logic rd_last;
        logic out_free;
    } dp_stat_t;

endpackage

// File: src/wnlt_ctrl.sv
// Controller state machine of the neighbor list: sequences add, scan,
// compaction and listing. Depends on wnlt_pkg.
module wnlt_ctrl
    import wnlt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] kind,
    output logic       in_stall,
    input  dp_stat_t   stat,
    output ctl_cmd_t   cmd
);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_SCAN       = 4'd1;
    localparam logic [3:0] S_SHIFT      = 4'd2;
    localparam logic [3:0] S_LIST_START = 4'd3;
    localparam logic [3:0] S_LIST_OUT   = 4'd4;
    localparam logic [3:0] S_ADD_OUT    = 4'd5;
    localparam logic [3:0] S_FOUND_OUT  = 4'd6;
    localparam logic [3:0] S_REM_OUT    = 4'd7;
    localparam logic [3:0] S_MISS_OUT   = 4'd8;
    localparam logic [3:0] S_EMPTY_OUT  = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [1:0] kind_reg;
    logic       accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // State register, and the operation code held for the scan decision
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= KIND_ADD;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                kind_reg <= kind;
            end
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.op_load = 1'b1;
                    cmd.ptr_clr = 1'b1;
                    unique case (kind)
                        KIND_ADD:    state_next = S_ADD_OUT;
                        KIND_REMOVE: state_next = S_SCAN;
                        KIND_FIND:   state_next = S_SCAN;
                        KIND_LIST:   state_next = S_LIST_START;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                priority if (stat.cnt_zero)
                begin
                    state_next = S_MISS_OUT;
                end
                else if (stat.rd_vld && stat.rd_match)
                begin
                    if (kind_reg == KIND_REMOVE)
                    begin
                        cmd.ptr_after_match = 1'b1;
                        state_next          = S_SHIFT;
                    end
                    else
                    begin
                        state_next = S_FOUND_OUT;
                    end
                end
                else if (stat.rd_vld && stat.rd_last)
                begin
                    state_next = S_MISS_OUT;
                end
                else if (stat.ptr_lt_cnt)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.ptr_inc = 1'b1;
                end
            end
            S_SHIFT:
            begin
                // Move each later entry down by one, reads one ahead of writes
                cmd.shift_wr = stat.rd_vld;
                if (stat.ptr_lt_cnt)
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.ptr_inc = 1'b1;
                end
                else if (!stat.rd_vld)
                begin
                    state_next = S_REM_OUT;
                end
            end
            S_LIST_START:
            begin
                if (stat.cnt_zero)
                begin
                    state_next = S_EMPTY_OUT;
                end
                else
                begin
                    cmd.rd_en   = 1'b1;
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_LIST_OUT;
                end
            end
            S_LIST_OUT:
            begin
                // Emit the read entry and fetch the next one at the same edge
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_OK;
                    cmd.out_tag    = 1'b1;
                    cmd.out_entry  = 1'b1;
                    cmd.out_last   = stat.rd_last;
                    if (stat.rd_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd_en   = 1'b1;
                        cmd.ptr_inc = 1'b1;
                    end
                end
            end
            S_ADD_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_last = 1'b1;
                    if (stat.cnt_full)
                    begin
                        cmd.out_status = ST_FULL;
                    end
                    else
                    begin
                        cmd.out_status = ST_OK;
                        cmd.add_wr     = 1'b1;
                        cmd.cnt_inc    = 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            S_FOUND_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_OK;
                    cmd.out_entry  = 1'b1;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_REM_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_OK;
                    cmd.cnt_dec    = 1'b1;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_MISS_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_NOTFOUND;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_EMPTY_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = ST_EMPTY;
                    cmd.out_last   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/wnlt_dp.sv
// Datapath of the neighbor list: edge store, walk pointer, entry count,
// vertex id register and the output word register. Depends on wnlt_pkg.
module wnlt_dp
    import wnlt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctl_cmd_t                cmd,
    output dp_stat_t                stat,
    input  logic [KEY_W-1:0]        neighbor,
    input  logic signed [WT_W-1:0]  weight,
    input  logic                    cfg_wr_en,
    input  logic [VTX_W-1:0]        cfg_wr_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              status,
    output logic [VTX_W-1:0]        source_vertex,
    output logic [KEY_W-1:0]        edge_neighbor,
    output logic signed [WT_W-1:0]  edge_weight,
    output logic [CNT_W-1:0]        entry_count,
    output logic                    last
);

    entry_t             mem [CAPACITY];
    entry_t             rd_data_reg;
    logic [ADDR_W-1:0]  rd_idx_reg;
    logic               rd_vld_reg;
    logic [CNT_W-1:0]   ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [KEY_W-1:0]   key_reg;
    logic [WT_W-1:0]    wt_reg;
    logic [VTX_W-1:0]   vertex_id_reg;

    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [VTX_W-1:0]   out_src_reg;
    logic [KEY_W-1:0]   out_nb_reg;
    logic [WT_W-1:0]    out_wt_reg;
    logic [CNT_W-1:0]   out_count_reg;
    logic               out_last_reg;

    logic               mem_we;
    logic [ADDR_W-1:0]  wr_addr;
    entry_t             wr_data;

    // Status toward the controller
    assign stat.cnt_zero   = (count_reg == '0);
    assign stat.cnt_full   = (count_reg >= CNT_W'(CAPACITY));
    assign stat.ptr_lt_cnt = (ptr_reg < count_reg);
    assign stat.rd_vld     = rd_vld_reg;
    assign stat.rd_match   = (rd_data_reg.key == key_reg);
    assign stat.rd_last    = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);
    assign stat.out_free   = !out_valid_reg || !out_stall;

    // Entry count after this cycle's update
    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Control registers: walk pointer, count, read tracking, config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg       <= '0;
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            vertex_id_reg <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_vld_reg <= cmd.rd_en;
            if (cmd.ptr_clr)
            begin
                ptr_reg <= '0;
            end
            else if (cmd.ptr_after_match)
            begin
                ptr_reg <= CNT_W'(rd_idx_reg) + CNT_W'(1);
            end
            else if (cmd.ptr_inc)
            begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end
            if (cfg_wr_en)
            begin
                vertex_id_reg <= cfg_wr_data;
            end
        end
    end

    // Latch the operand of the accepted word
    always_ff @(posedge clk)
    begin
        if (cmd.op_load)
        begin
            key_reg <= neighbor;
            wt_reg  <= weight;
        end
    end

    // Store write port: append at the tail or move an entry down one place
    assign mem_we  = cmd.add_wr || cmd.shift_wr;
    assign wr_addr = cmd.add_wr ? count_reg[ADDR_W-1:0] : (rd_idx_reg - ADDR_W'(1));
    assign wr_data = cmd.add_wr ? entry_t'{key: key_reg, wt: wt_reg} : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Store read port, registered
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[ptr_reg[ADDR_W-1:0]];
            rd_idx_reg  <= ptr_reg[ADDR_W-1:0];
        end
    end

    // Output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg <= cmd.out_status;
            out_src_reg    <= cmd.out_tag ? vertex_id_reg : '0;
            out_nb_reg     <= cmd.out_entry ? rd_data_reg.key : '0;
            out_wt_reg     <= cmd.out_entry ? rd_data_reg.wt : '0;
            out_count_reg  <= count_next;
            out_last_reg   <= cmd.out_last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign source_vertex = out_src_reg;
    assign edge_neighbor = out_nb_reg;
    assign edge_weight   = out_wt_reg;
    assign entry_count   = out_count_reg;
    assign last          = out_last_reg;

endmodule

// File: src/weighted_neighbor_list_table.sv
// Add appends at the tail; find scans the entries in order to a match or the entry count; remove
// scans to a match, then moves every later entry down one place; list gives its words one a
// cycle while the output is not stalled. Throughput: one operation at a time, next word taken
// the cycle after the last result is registered.
// Reset (rst_n, asynchronous, active low) empties the list and clears vertex_id;
// no clearing pass, stored entries are read only below the entry count.
module weighted_neighbor_list_table
    import wnlt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [1:0]              kind,
    input  logic [KEY_W-1:0]        neighbor,
    input  logic signed [WT_W-1:0]  weight,
    input  logic                    cfg_wr_en,
    input  logic [VTX_W-1:0]        cfg_wr_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [1:0]              status,
    output logic [VTX_W-1:0]        source_vertex,
    output logic [KEY_W-1:0]        edge_neighbor,
    output logic signed [WT_W-1:0]  edge_weight,
    output logic [CNT_W-1:0]        entry_count,
    output logic                    last
);

    ctl_cmd_t cmd;
    dp_stat_t stat;

    wnlt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    wnlt_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .neighbor      (neighbor),
        .weight        (weight),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .source_vertex (source_vertex),
        .edge_neighbor (edge_neighbor),
        .edge_weight   (edge_weight),
        .entry_count   (entry_count),
        .last          (last)
    );

endmodule

// File: src/wnlt_checker.sv
// Port-level checks of the neighbor list, bound to the top level.
// Depends on wnlt_pkg and assert_macros.svh.
module wnlt_checker
    import wnlt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [1:0]              status,
    input  logic [VTX_W-1:0]        source_vertex,
    input  logic [KEY_W-1:0]        edge_neighbor,
    input  logic [CNT_W-1:0]        entry_count,
    input  logic                    last
);

`include "assert_macros.svh"

    // A stalled word stays offered
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    // One operation at a time: busy right after an accept
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    // Full reported only at capacity
    `ASSERT_SAME(a_full_count, clk, rst_n, out_valid && (status == ST_FULL),
                 entry_count == CNT_W'(CAPACITY))
    // Empty list gives a single closing word with nothing held or reported
    `ASSERT_SAME(a_empty_word, clk, rst_n, out_valid && (status == ST_EMPTY),
                 last && (entry_count == '0) && (source_vertex == '0) && (edge_neighbor == '0))
    // Count never exceeds capacity
    `ASSERT_SAME(a_count_range, clk, rst_n, out_valid, entry_count <= CNT_W'(CAPACITY))

endmodule

bind weighted_neighbor_list_table wnlt_checker u_wnlt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .source_vertex (source_vertex),
    .edge_neighbor (edge_neighbor),
    .entry_count   (entry_count),
    .last          (last)
);
